// File: hw/rtl/swm_pkg.sv
package swm_pkg;

   localparam int MAX_FRAME        = 4096;
   localparam int COEF_TABLE_DEPTH = 1024;
   localparam int COEF_ADDR_W      = $clog2(COEF_TABLE_DEPTH);
   localparam int IDX_W            = $clog2(MAX_FRAME);
   localparam int LEN_W            = 13;
   localparam int EIDX_W           = COEF_ADDR_W + 5;

   localparam int ONE_Q16 = 65536;
   localparam logic [18:0] POS_RESET = 19'h70000;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam logic [2:0] WIN_RECT     = 3'd0;
   localparam logic [2:0] WIN_HAMMING  = 3'd1;
   localparam logic [2:0] WIN_BLACKMAN = 3'd2;
   localparam logic [2:0] WIN_HANN     = 3'd3;
   localparam logic [2:0] WIN_GAUSSIAN = 3'd4;
   localparam logic [2:0] WIN_WELCH    = 3'd5;
   localparam logic [2:0] WIN_BARTLETT = 3'd6;

   localparam logic [1:0] CSR_WINDOW_KIND   = 2'd0;
   localparam logic [1:0] CSR_FRAME_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_POSITION_STEP = 2'd2;

   typedef struct packed {
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] windowed_re;
      logic signed [15:0] windowed_im;
      logic               frame_last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ADDR, ST_ROM, ST_MUL, ST_COEF, ST_PROD
   } ctrl_state_type;

   typedef struct packed {
      logic cap;
      logic addr;
      logic rom;
      logic mul;
      logic coef;
      logic prod;
   } dp_cmd_type;

   typedef logic [16:0] cos_tab_type [0:COEF_TABLE_DEPTH];
   typedef logic [16:0] exp_tab_type [0:COEF_TABLE_DEPTH-1];

   // Divisor (2n-1)(2n) of the n-th cosine series term.
   function automatic longint unsigned cos_series_div(input longint unsigned v,
                                                      input int n);
      unique case (n)
         1:       return v / 64'd2;
         2:       return v / 64'd12;
         3:       return v / 64'd30;
         4:       return v / 64'd56;
         5:       return v / 64'd90;
         6:       return v / 64'd132;
         7:       return v / 64'd182;
         default: return v / 64'd240;
      endcase
   endfunction

   // Divisor n of the n-th exponential series term.
   function automatic longint unsigned exp_series_div(input longint unsigned v,
                                                      input int n);
      unique case (n)
         1:       return v;
         2:       return v / 64'd2;
         3:       return v / 64'd3;
         4:       return v / 64'd4;
         5:       return v / 64'd5;
         6:       return v / 64'd6;
         7:       return v / 64'd7;
         8:       return v / 64'd8;
         9:       return v / 64'd9;
         10:      return v / 64'd10;
         11:      return v / 64'd11;
         default: return v / 64'd12;
      endcase
   endfunction

   // Quarter-wave cosine, built with a fixed Q30 series at elaboration.
   function automatic cos_tab_type build_cos_table();
      cos_tab_type t;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      for (int k = 0; k <= COEF_TABLE_DEPTH; k++) begin
         x = (HALF_PI_Q30 * longint'(k)) / COEF_TABLE_DEPTH;
         x2 = (x * x) >> 30;
         term = 64'd1 << 30;
         sum = longint'(term);
         for (int n = 1; n <= 8; n++) begin
            term = cos_series_div((term * x2) >> 30, n);
            if ((n & 1) == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum <= 0) begin
            t[k] = 17'd0;
         end else begin
            sum = (sum + 8192) >>> 14;
            t[k] = (sum > ONE_Q16) ? 17'(ONE_Q16) : 17'(sum);
         end
      end
      return t;
   endfunction

   // exp(-16 k / depth) in Q16: series for exp(-x), then squared four times.
   function automatic exp_tab_type build_exp_table();
      exp_tab_type t;
      longint unsigned x;
      longint unsigned term;
      longint unsigned e;
      longint sum;
      for (int k = 0; k < COEF_TABLE_DEPTH; k++) begin
         x = (longint'(k) << 30) / COEF_TABLE_DEPTH;
         term = 64'd1 << 30;
         sum = longint'(term);
         for (int n = 1; n <= 12; n++) begin
            term = exp_series_div((term * x) >> 30, n);
            if ((n & 1) == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         e = (sum > 0) ? longint'(sum) : 64'd0;
         for (int i = 0; i < 4; i++) begin
            e = (e * e + (64'd1 << 29)) >> 30;
         end
         t[k] = 17'((e + 64'd8192) >> 14);
      end
      return t;
   endfunction

   localparam cos_tab_type COS_TABLE = build_cos_table();
   localparam exp_tab_type EXP_TABLE = build_exp_table();

   function automatic logic [16:0] clamp_coef(input logic signed [21:0] w);
      if (w < 0) return 17'd0;
      if (w > 22'sd65536) return 17'(ONE_Q16);
      return w[16:0];
   endfunction

endpackage

// File: hw/rtl/spectral_window_multiplier_top.sv
// A sample beat is accepted only while the controller is idle, and its result
// beat is offered after a five-step datapath sequence (address, cosine table
// read, coefficient multiply and exp table read, coefficient, product). No new
// sample is accepted while the sequence runs, but one is taken while the
// previous result still waits in the output register, which is not overwritten.
// Synchronous active-high reset restores the register defaults and the position.
module spectral_window_multiplier_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  swm_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output swm_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [17:0]              csr_wdata
);

   swm_pkg::dp_cmd_type cmd;

   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   swm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hw/rtl/swm_ctrl.sv
module swm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output swm_pkg::dp_cmd_type cmd
);

   swm_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = (state_ff == swm_pkg::ST_IDLE) && !reset;
      unique case (state_ff)
         swm_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.cap = 1'b1;
               state_in = swm_pkg::ST_ADDR;
            end
         end
         swm_pkg::ST_ADDR: begin
            cmd.addr = 1'b1;
            state_in = swm_pkg::ST_ROM;
         end
         swm_pkg::ST_ROM: begin
            cmd.rom = 1'b1;
            state_in = swm_pkg::ST_MUL;
         end
         swm_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = swm_pkg::ST_COEF;
         end
         swm_pkg::ST_COEF: begin
            cmd.coef = 1'b1;
            state_in = swm_pkg::ST_PROD;
         end
         swm_pkg::ST_PROD: begin
            // The result register is loaded only once the previous beat has gone.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.prod = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = swm_pkg::ST_IDLE;
            end
         end
         default: state_in = swm_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == swm_pkg::ST_ADDR))
      else $error("accepted beat did not start the datapath sequence");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.prod |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded over an untaken beat");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.cap, cmd.addr, cmd.rom, cmd.mul, cmd.coef, cmd.prod}))
      else $error("more than one datapath command at once");

endmodule

// File: hw/rtl/swm_datapath.sv
module swm_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  swm_pkg::dp_cmd_type      cmd,
   input  swm_pkg::req_payload_type req_data,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [17:0]              csr_wdata,
   output swm_pkg::rsp_payload_type rsp_data
);

   localparam int L = swm_pkg::COEF_ADDR_W;

   logic [2:0]                     kind_ff;
   logic [swm_pkg::LEN_W-1:0]      flen_ff;
   logic [17:0]                    step_ff;
   logic [18:0]                    pos_ff, pos_in;
   logic [swm_pkg::IDX_W-1:0]      sidx_ff, sidx_in;

   logic [swm_pkg::LEN_W-1:0]      eff_len;
   logic                           last_in;

   logic signed [15:0]             re_ff, im_ff;
   logic signed [18:0]             p_ff;
   logic                           last_ff;

   logic [L:0]                     a1_ff, a1_in, a2_ff, a2_in;
   logic                           n1_ff, n1_in, n2_ff, n2_in;
   logic signed [37:0]             p2raw_ff;

   logic signed [17:0]             c_ff, c2_ff;
   logic [20:0]                    p2_ff;
   logic [swm_pkg::EIDX_W-1:0]     eidx_ff;

   logic signed [19:0]             m1_ff, m2_ff;
   logic signed [18:0]             half_ff;
   logic [16:0]                    e_ff;
   logic [16:0]                    w_ff;

   // Effective frame length, held to one up to the largest frame.
   always_comb begin
      if (flen_ff == '0) eff_len = swm_pkg::LEN_W'(1);
      else if (flen_ff > swm_pkg::LEN_W'(swm_pkg::MAX_FRAME))
         eff_len = swm_pkg::LEN_W'(swm_pkg::MAX_FRAME);
      else eff_len = flen_ff;
   end

   assign last_in = (swm_pkg::LEN_W'(sidx_ff) + swm_pkg::LEN_W'(1)) >= eff_len;
   assign pos_in  = last_in ? swm_pkg::POS_RESET : pos_ff + 19'(step_ff);
   assign sidx_in = last_in ? '0 : sidx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= swm_pkg::WIN_RECT;
         flen_ff <= swm_pkg::LEN_W'(1024);
         step_ff <= 18'd128;
         pos_ff  <= swm_pkg::POS_RESET;
         sidx_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               swm_pkg::CSR_WINDOW_KIND:   kind_ff <= csr_wdata[2:0];
               swm_pkg::CSR_FRAME_LENGTH:  flen_ff <= csr_wdata[swm_pkg::LEN_W-1:0];
               swm_pkg::CSR_POSITION_STEP: step_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.cap) begin
            pos_ff  <= pos_in;
            sidx_ff <= sidx_in;
         end
      end
   end

   // Cosine table addresses: the offset within a quadrant is rounded to the
   // table grid, and odd quadrants read the table mirrored.
   function automatic logic [L:0] quad_addr(input logic [17:0] phase);
      logic [16:0] idx;
      idx = (17'(phase[15:0]) + 17'(1 << (15 - L))) >> (16 - L);
      if (phase[16]) return (L+1)'(swm_pkg::COEF_TABLE_DEPTH) - idx[L:0];
      return idx[L:0];
   endfunction

   always_comb begin
      logic [17:0] ph1;
      logic [17:0] ph2;
      ph2 = {p_ff[15:0], 2'b00};
      if (kind_ff == swm_pkg::WIN_HANN) ph1 = p_ff[17:0];
      else ph1 = {p_ff[16:0], 1'b0};
      a1_in = quad_addr(ph1);
      a2_in = quad_addr(ph2);
      n1_in = ph1[17] ^ ph1[16];
      n2_in = ph2[17] ^ ph2[16];
   end

   always_ff @(posedge clock) begin
      logic signed [38:0] p2sum;
      logic [21:0]        esum;
      logic signed [35:0] raw1;
      logic signed [35:0] raw2;
      logic signed [35:0] r1;
      logic signed [35:0] r2;
      logic signed [21:0] wsum;
      logic [18:0]        absp;
      logic signed [33:0] pre;
      logic signed [33:0] pim;
      if (cmd.cap) begin
         re_ff   <= req_data.sample_re;
         im_ff   <= req_data.sample_im;
         p_ff    <= pos_ff;
         last_ff <= last_in;
      end
      if (cmd.addr) begin
         a1_ff    <= a1_in;
         a2_ff    <= a2_in;
         n1_ff    <= n1_in;
         n2_ff    <= n2_in;
         p2raw_ff <= p_ff * p_ff;
      end
      if (cmd.rom) begin
         c_ff  <= n1_ff ? -$signed({1'b0, swm_pkg::COS_TABLE[a1_ff]})
                        :  $signed({1'b0, swm_pkg::COS_TABLE[a1_ff]});
         c2_ff <= n2_ff ? -$signed({1'b0, swm_pkg::COS_TABLE[a2_ff]})
                        :  $signed({1'b0, swm_pkg::COS_TABLE[a2_ff]});
         p2sum = 39'(p2raw_ff) + 39'sd32768;
         p2_ff <= p2sum[36:16];
         esum  = 22'(p2sum[36:16]) + 22'(1 << (16 - L));
         eidx_ff <= swm_pkg::EIDX_W'(esum >> (17 - L));
      end
      if (cmd.mul) begin
         if (kind_ff == swm_pkg::WIN_HANN) raw1 = c_ff * c_ff;
         else raw1 = c_ff * 18'sd30147;
         raw2 = c2_ff * 18'sd5243;
         r1 = (raw1 + 36'sd32768) >>> 16;
         r2 = (raw2 + 36'sd32768) >>> 16;
         m1_ff   <= 20'(r1);
         m2_ff   <= 20'(r2);
         half_ff <= (19'(c_ff) + 19'sd1) >>> 1;
         if (eidx_ff >= swm_pkg::EIDX_W'(swm_pkg::COEF_TABLE_DEPTH)) e_ff <= 17'd0;
         else e_ff <= swm_pkg::EXP_TABLE[eidx_ff[L-1:0]];
      end
      if (cmd.coef) begin
         absp = p_ff[18] ? 19'(-p_ff) : 19'(p_ff);
         unique case (kind_ff)
            swm_pkg::WIN_HAMMING:  wsum = 22'sd35389 + 22'(m1_ff);
            swm_pkg::WIN_BLACKMAN: wsum = 22'sd27525 + 22'(half_ff) + 22'(m2_ff);
            swm_pkg::WIN_HANN:     wsum = 22'(m1_ff);
            swm_pkg::WIN_GAUSSIAN: wsum = $signed({5'd0, e_ff});
            swm_pkg::WIN_WELCH:    wsum = 22'sd65536 - $signed({1'b0, p2_ff});
            swm_pkg::WIN_BARTLETT: begin
               if (absp < 19'd65536) wsum = 22'sd65536 - $signed({3'd0, absp});
               else wsum = 22'sd0;
            end
            default:               wsum = 22'sd65536;
         endcase
         w_ff <= swm_pkg::clamp_coef(wsum);
      end
      if (cmd.prod) begin
         pre = re_ff * $signed({1'b0, w_ff});
         pim = im_ff * $signed({1'b0, w_ff});
         pre = (pre + 34'sd32768) >>> 16;
         pim = (pim + 34'sd32768) >>> 16;
         rsp_data.windowed_re <= pre[15:0];
         rsp_data.windowed_im <= pim[15:0];
         rsp_data.frame_last  <= last_ff;
      end
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   swm_pkg::req_payload_type req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   swm_pkg::rsp_payload_type rsp_data;
   logic                     csr_we = 1'b0;
   logic [1:0]               csr_index = swm_pkg::CSR_WINDOW_KIND;
   logic [17:0]              csr_wdata = '0;

   spectral_window_multiplier_top u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: configuration, running position and sample counter.
   logic [2:0]  kind_q;
   logic [12:0] len_q;
   logic [17:0] step_q;
   logic [18:0] pos_q;
   int unsigned idx_q;

   swm_pkg::rsp_payload_type windowed_q[$];
   int unsigned     mismatches = 0;
   int unsigned     beats_in = 0;
   int unsigned     beats_out = 0;
   int unsigned     idle_cycles = 0;
   bit              stall_free = 1'b0;
   bit              hold_rsp = 1'b0;
   int unsigned     kinds_seen = 0;

   function automatic longint round16(longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic longint cos_lookup(int unsigned k);
      if (k > swm_pkg::COEF_TABLE_DEPTH) k = swm_pkg::COEF_TABLE_DEPTH;
      return longint'(swm_pkg::COS_TABLE[k]);
   endfunction

   function automatic longint cos_of_phase(logic [17:0] ph);
      longint idx;
      idx = (longint'(ph[15:0]) * swm_pkg::COEF_TABLE_DEPTH + 32768) >>> 16;
      unique case (ph[17:16])
         2'd0: return cos_lookup(idx);
         2'd1: return -cos_lookup(swm_pkg::COEF_TABLE_DEPTH - idx);
         2'd2: return -cos_lookup(idx);
         default: return cos_lookup(swm_pkg::COEF_TABLE_DEPTH - idx);
      endcase
   endfunction

   function automatic longint clip_coef(longint w);
      if (w < 0) return 0;
      return (w > swm_pkg::ONE_Q16) ? swm_pkg::ONE_Q16 : w;
   endfunction

   function automatic longint window_at(logic [18:0] up);
      longint p, c, c2, p2, ei;
      p = longint'($signed(up));
      unique case (kind_q)
         swm_pkg::WIN_HAMMING: begin
            c = cos_of_phase(18'(up * 2));
            return clip_coef(35389 + round16(30147 * c));
         end
         swm_pkg::WIN_BLACKMAN: begin
            c = cos_of_phase(18'(up * 2));
            c2 = cos_of_phase(18'(up * 4));
            return clip_coef(27525 + round16(32768 * c) + round16(5243 * c2));
         end
         swm_pkg::WIN_HANN: begin
            c = cos_of_phase(18'(up));
            return clip_coef(round16(c * c));
         end
         swm_pkg::WIN_GAUSSIAN: begin
            p2 = round16(p * p);
            ei = (8 * p2 * swm_pkg::COEF_TABLE_DEPTH + (64'sd1 <<< 19)) >>> 20;
            if (ei >= swm_pkg::COEF_TABLE_DEPTH) return 0;
            return clip_coef(longint'(swm_pkg::EXP_TABLE[ei]));
         end
         swm_pkg::WIN_WELCH: return clip_coef(swm_pkg::ONE_Q16 - round16(p * p));
         swm_pkg::WIN_BARTLETT: begin
            if (p > -swm_pkg::ONE_Q16 && p < swm_pkg::ONE_Q16)
               return swm_pkg::ONE_Q16 - ((p < 0) ? -p : p);
            return 0;
         end
         default: return swm_pkg::ONE_Q16;
      endcase
   endfunction

   function automatic swm_pkg::rsp_payload_type window_sample(swm_pkg::req_payload_type s);
      swm_pkg::rsp_payload_type r;
      longint w;
      int unsigned len;
      len = (len_q < 1) ? 1 : ((len_q > swm_pkg::MAX_FRAME) ? swm_pkg::MAX_FRAME : len_q);
      w = window_at(pos_q);
      r.windowed_re = 16'(round16(longint'(s.sample_re) * w));
      r.windowed_im = 16'(round16(longint'(s.sample_im) * w));
      r.frame_last = (idx_q + 1 >= len);
      if (r.frame_last) begin
         pos_q = swm_pkg::POS_RESET;
         idx_q = 0;
      end else begin
         pos_q = pos_q + 19'(step_q);
         idx_q++;
      end
      return r;
   endfunction

   // Result side: compare against the oldest expectation and idle at random.
   always @(posedge clock) begin
      swm_pkg::rsp_payload_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out++;
         if (windowed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", rsp_data);
         end else begin
            e = windowed_q.pop_front();
            if (rsp_data.windowed_re !== e.windowed_re ||
                rsp_data.windowed_im !== e.windowed_im ||
                rsp_data.frame_last !== e.frame_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", e, rsp_data);
            end
         end
      end
      rsp_ready <= !reset && !hold_rsp && (stall_free || $urandom_range(99) >= 16);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
         $display("[spectral_window_multiplier_top] ERROR");
         $finish;
      end
   end

   // The write enable stays high until the next send or drain lowers it.
   task automatic csr_write(logic [1:0] idx, logic [17:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      unique case (idx)
         swm_pkg::CSR_WINDOW_KIND: kind_q = val[2:0];
         swm_pkg::CSR_FRAME_LENGTH: len_q = val[12:0];
         default: step_q = val;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      csr_we <= 1'b0;
      while (windowed_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Offer one beat; the prediction is made at the accepting edge. Valid is
   // left high afterwards so that back-to-back beats need no gap.
   task automatic send(swm_pkg::req_payload_type s, bit gaps,
                       output swm_pkg::rsp_payload_type r);
      csr_we <= 1'b0;
      while (gaps && !stall_free && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (!req_ready);
      r = window_sample(s);
      windowed_q.push_back(r);
      beats_in++;
   endtask

   typedef struct {
      logic [15:0] re;
      logic [15:0] im;
      bit          known;
      logic [15:0] exp_re;
      logic [15:0] exp_im;
   } vector_row_type;

   vector_row_type vectors[] = '{
      '{16'h7FFF, 16'h8000, 1, 16'h7FFF, 16'h8000},
      '{16'h8000, 16'h7FFF, 1, 16'h8000, 16'h7FFF},
      '{16'h0000, 16'hFFFF, 1, 16'h0000, 16'hFFFF},
      '{16'h0001, 16'h5555, 1, 16'h0001, 16'h5555},
      '{16'hAAAA, 16'h0000, 1, 16'hAAAA, 16'h0000}
   };

   initial begin
      swm_pkg::req_payload_type s;
      swm_pkg::rsp_payload_type r;
      logic [12:0] flen;
      kind_q = swm_pkg::WIN_RECT;
      len_q = 13'd1024;
      step_q = 18'd128;
      pos_q = swm_pkg::POS_RESET;
      idx_q = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Rectangle after reset: output equals input, frame not yet ended.
      foreach (vectors[i]) begin
         s.sample_re = vectors[i].re;
         s.sample_im = vectors[i].im;
         send(s, 1'b0, r);
         if (vectors[i].known && (r.windowed_re !== vectors[i].exp_re ||
             r.windowed_im !== vectors[i].exp_im || r.frame_last)) begin
            mismatches++;
            if (mismatches <= 10) $display("directed row %0d disagrees with table", i);
         end
      end
      drain();

      // Every kind over a short frame, with extreme real and random imaginary samples.
      for (int k = 0; k < 8; k++) begin
         csr_write(swm_pkg::CSR_WINDOW_KIND, 18'(k));
         csr_write(swm_pkg::CSR_FRAME_LENGTH, 18'd5);
         csr_write(swm_pkg::CSR_POSITION_STEP, 18'd26214);
         repeat (5) begin
            s.sample_re = ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
            s.sample_im = 16'($urandom);
            send(s, 1'b0, r);
         end
         kinds_seen++;
         drain();
      end

      // Length zero, length beyond the maximum, the largest step.
      csr_write(swm_pkg::CSR_FRAME_LENGTH, 18'd0);
      csr_write(swm_pkg::CSR_POSITION_STEP, 18'h3FFFF);
      repeat (3) begin
         s = swm_pkg::req_payload_type'($urandom);
         send(s, 1'b1, r);
      end
      drain();
      csr_write(swm_pkg::CSR_FRAME_LENGTH, 18'h1FFF);
      csr_write(swm_pkg::CSR_POSITION_STEP, 18'd0);
      repeat (4) begin
         s = swm_pkg::req_payload_type'($urandom);
         send(s, 1'b1, r);
      end
      drain();

      // Random phases; the position wraps when step times length is large.
      for (int ph = 0; ph < 30; ph++) begin
         flen = ($urandom_range(9) == 0) ? 13'($urandom_range(8191))
                                         : 13'($urandom_range(1, 64));
         csr_write(swm_pkg::CSR_WINDOW_KIND, 18'($urandom_range(7)));
         csr_write(swm_pkg::CSR_FRAME_LENGTH, 18'(flen));
         csr_write(swm_pkg::CSR_POSITION_STEP, ($urandom_range(4) == 0)
                   ? 18'($urandom) : 18'((131072 / ((flen == 0) ? 1 : flen))));
         stall_free = (ph == 3);
         if (ph == 5) fork
            begin
               hold_rsp = 1'b1;
               repeat (300) @(posedge clock);
               hold_rsp = 1'b0;
            end
         join_none
         repeat (50) begin
            s = swm_pkg::req_payload_type'($urandom);
            send(s, 1'b1, r);
         end
         // Change the length mid frame now and then.
         if (ph % 7 == 6) begin
            drain();
            csr_write(swm_pkg::CSR_FRAME_LENGTH, 18'($urandom_range(1, 8)));
            repeat (10) begin
               s = swm_pkg::req_payload_type'($urandom);
               send(s, 1'b1, r);
            end
         end
         drain();
      end
      stall_free = 1'b0;

      $display("Sent %0d beats, received %0d, over %0d window kinds and frame extremes.",
               beats_in, beats_out, kinds_seen);
      if (mismatches == 0 && windowed_q.size() == 0)
         $display("[spectral_window_multiplier_top] OK");
      else
         $display("[spectral_window_multiplier_top] ERROR");
      $finish;
   end

endmodule
